FILE: hw/rtl/ray_box_intersect_3d_unit_macros.svh
// ----------------------------------------------------------------------------
// Ray/box intersect assertion macros
// Shared same-cycle and next-cycle implication assertion forms.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_INTERSECT_3D_UNIT_MACROS_SVH
`define RAY_BOX_INTERSECT_3D_UNIT_MACROS_SVH

// same-cycle implication
`define RBI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbi assertion failed");

// next-cycle implication
`define RBI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbi assertion failed");

`endif

FILE: hw/rtl/rbi_pkg.sv
// ----------------------------------------------------------------------------
// Ray/box intersect package
// Types shared between the front stage and the resolve stages.
// ----------------------------------------------------------------------------
package rbi_pkg;

   typedef struct packed {
      logic in_box;  // start strictly inside the box
      logic zmiss;   // some zero-direction axis has start outside its slab
   } rbi_flags_type;

endpackage

FILE: hw/rtl/rbi_slab_div.sv
// ----------------------------------------------------------------------------
// Ray/box intersect slab divider
// Pipelined restoring divider: (num << FB) / den, truncated toward zero and
// saturated to the signed CW range. One quotient bit per stage.
// Input register, quotient stages and output register advance only while en is high.
// ----------------------------------------------------------------------------
module rbi_slab_div #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CW:0]   num,
   input  logic signed [FB+1:0] den,
   output logic signed [CW-1:0] quo
);

   localparam int DW = FB + 2;
   localparam int NW = CW + 1 + FB;

   logic [CW:0]    un_c;
   logic [DW-1:0]  ud_c;
   logic [NW-1:0]  nn_c;

   logic [DW-1:0]  rem_ff [CW+1];
   logic [CW-1:0]  low_ff [CW+1];
   logic [CW-1:0]  q_ff   [CW+1];
   logic [DW-1:0]  ud_ff  [CW+1];
   logic           neg_ff [CW+1];
   logic           ovf_ff [CW+1];

   logic [CW-1:0]  lim_c;
   logic [CW-1:0]  qs_c;
   logic [CW-1:0]  quo_in;
   logic [CW-1:0]  quo_ff;

   assign un_c = num[CW] ? (~num + 1'b1) : num;
   assign ud_c = den[DW-1] ? (~den + 1'b1) : den;
   assign nn_c = {un_c, {FB{1'b0}}};

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= num[CW] ^ den[DW-1];
         ud_ff[0]  <= ud_c;
         ovf_ff[0] <= {1'b0, nn_c[NW-1:CW]} >= ud_c;
         rem_ff[0] <= {1'b0, nn_c[NW-1:CW]};
         low_ff[0] <= nn_c[CW-1:0];
         q_ff[0]   <= '0;
      end
   end

   for (genvar k = 1; k <= CW; k++) begin : g_step
      logic [DW:0] trial;
      logic        ge;
      logic [DW:0] diff;
      assign trial = {rem_ff[k-1], low_ff[k-1][CW-1]};
      assign ge    = trial >= {1'b0, ud_ff[k-1]};
      assign diff  = trial - {1'b0, ud_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_ff[k] <= {low_ff[k-1][CW-2:0], 1'b0};
            q_ff[k]   <= {q_ff[k-1][CW-2:0], ge};
            ud_ff[k]  <= ud_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign lim_c  = neg_ff[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
   assign qs_c   = (ovf_ff[CW] || (q_ff[CW] > lim_c)) ? lim_c : q_ff[CW];
   assign quo_in = neg_ff[CW] ? (~qs_c + 1'b1) : qs_c;

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = $signed(quo_ff);

endmodule

FILE: hw/rtl/rbi_resolve.sv
// ----------------------------------------------------------------------------
// Ray/box intersect resolve stages
// Four stages: slab intervals, entry/exit reduction, impact products and
// face pick, impact point and result register.
// ----------------------------------------------------------------------------
module rbi_resolve #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [CW-2:0]         max_len,
   input  rbi_pkg::rbi_flags_type flags,
   input  logic signed [CW-1:0]  t_lo [3],
   input  logic signed [CW-1:0]  t_hi [3],
   input  logic signed [CW-1:0]  s    [3],
   input  logic signed [FB+1:0]  d    [3],
   output logic                  hit,
   output logic [CW-2:0]         hit_dist,
   output logic signed [CW-1:0]  pos  [3],
   output logic signed [FB+1:0]  nrm  [3]
);

   localparam int DW = FB + 2;
   localparam int PW = CW + DW;
   localparam int SW = CW + 3;
   localparam logic signed [DW-1:0] ONE_V  = {2'b01, {FB{1'b0}}};
   localparam logic signed [DW-1:0] NONE_V = {2'b11, {FB{1'b0}}};
   localparam logic signed [DW-1:0] DMAX_V = {1'b0, {(DW-1){1'b1}}};

   // stage 1
   logic signed [CW-1:0] lo1_ff [3];
   logic signed [CW-1:0] hi1_ff [3];
   logic signed [CW-1:0] te1_ff [3];
   logic signed [CW-1:0] s1_ff  [3];
   logic signed [DW-1:0] d1_ff  [3];
   logic [2:0]           act1_ff;
   rbi_pkg::rbi_flags_type fl1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            lo1_ff[a]  <= (t_lo[a] > t_hi[a]) ? t_hi[a] : t_lo[a];
            hi1_ff[a]  <= (t_lo[a] > t_hi[a]) ? t_lo[a] : t_hi[a];
            te1_ff[a]  <= d[a][DW-1] ? t_hi[a] : t_lo[a];
            s1_ff[a]   <= s[a];
            d1_ff[a]   <= d[a];
            act1_ff[a] <= d[a] != '0;
         end
         fl1_ff <= flags;
      end
   end

   // stage 2
   logic signed [CW-1:0] cl_c [3];
   logic signed [CW-1:0] ch_c [3];
   logic signed [CW-1:0] lim_c;
   logic signed [CW-1:0] m01_c, m2_c, tmin_c;
   logic signed [CW-1:0] n01_c, n2_c, tmax_c;

   logic signed [CW-1:0] te2_ff [3];
   logic signed [CW-1:0] s2_ff  [3];
   logic signed [DW-1:0] d2_ff  [3];
   logic [2:0]           act2_ff;
   logic [CW-2:0]        tmin2_ff;
   logic                 hit2_ff;
   logic                 inside2_ff;

   assign lim_c = $signed({1'b0, max_len});

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         cl_c[a] = act1_ff[a] ? lo1_ff[a] : '0;
         ch_c[a] = act1_ff[a] ? hi1_ff[a] : lim_c;
      end
   end

   assign m01_c  = (cl_c[0] > cl_c[1]) ? cl_c[0] : cl_c[1];
   assign m2_c   = (cl_c[2] > 0) ? cl_c[2] : '0;
   assign tmin_c = (m01_c > m2_c) ? m01_c : m2_c;
   assign n01_c  = (ch_c[0] < ch_c[1]) ? ch_c[0] : ch_c[1];
   assign n2_c   = (ch_c[2] < lim_c) ? ch_c[2] : lim_c;
   assign tmax_c = (n01_c < n2_c) ? n01_c : n2_c;

   always_ff @(posedge clock) begin
      if (en) begin
         te2_ff     <= te1_ff;
         s2_ff      <= s1_ff;
         d2_ff      <= d1_ff;
         act2_ff    <= act1_ff;
         tmin2_ff   <= tmin_c[CW-2:0];
         hit2_ff    <= !fl1_ff.zmiss && (tmin_c <= tmax_c);
         inside2_ff <= fl1_ff.in_box;
      end
   end

   // stage 3
   logic [CW-2:0]        dist_c;
   logic [2:0]           eq_c;
   logic [2:0]           face_c;

   logic signed [PW-1:0] p3_ff  [3];
   logic signed [CW-1:0] s3_ff  [3];
   logic signed [DW-1:0] d3_ff  [3];
   logic [2:0]           face3_ff;
   logic                 found3_ff;
   logic                 hit3_ff;
   logic [CW-2:0]        dist3_ff;

   assign dist_c = inside2_ff ? '0 : tmin2_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         eq_c[a] = act2_ff[a] && (te2_ff[a] == $signed({1'b0, tmin2_ff}));
      end
   end

   assign face_c = {eq_c[2] & ~eq_c[1] & ~eq_c[0], eq_c[1] & ~eq_c[0], eq_c[0]};

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            p3_ff[a] <= d2_ff[a] * $signed({1'b0, dist_c});
         end
         s3_ff     <= s2_ff;
         d3_ff     <= d2_ff;
         face3_ff  <= face_c;
         found3_ff <= !inside2_ff && (eq_c != '0);
         hit3_ff   <= inside2_ff || hit2_ff;
         dist3_ff  <= dist_c;
      end
   end

   // stage 4: result register
   logic signed [PW-1:0] sh_c   [3];
   logic signed [SW-1:0] sum_c  [3];
   logic signed [CW-1:0] pos_c  [3];
   logic signed [DW-1:0] nrm_c  [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sh_c[a]  = p3_ff[a] >>> FB;
         sum_c[a] = $signed({{3{s3_ff[a][CW-1]}}, s3_ff[a]}) + sh_c[a][SW-1:0];
         if ((sum_c[a][SW-1:CW-1] != '0) && (sum_c[a][SW-1:CW-1] != '1)) begin
            pos_c[a] = sum_c[a][SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end else begin
            pos_c[a] = sum_c[a][CW-1:0];
         end
         if (found3_ff) begin
            nrm_c[a] = face3_ff[a] ? (d3_ff[a][DW-1] ? ONE_V : NONE_V) : '0;
         end else if (d3_ff[a] == {1'b1, {(DW-1){1'b0}}}) begin
            nrm_c[a] = DMAX_V;
         end else begin
            nrm_c[a] = -d3_ff[a];
         end
      end
   end

   logic                 hit_ff;
   logic [CW-2:0]        dist_ff;
   logic signed [CW-1:0] pos_ff [3];
   logic signed [DW-1:0] nrm_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff  <= hit3_ff;
         dist_ff <= hit3_ff ? dist3_ff : '0;
         for (int a = 0; a < 3; a++) begin
            pos_ff[a] <= hit3_ff ? pos_c[a] : '0;
            nrm_ff[a] <= hit3_ff ? nrm_c[a] : '0;
         end
      end
   end

   assign hit      = hit_ff;
   assign hit_dist = dist_ff;
   assign pos      = pos_ff;
   assign nrm      = nrm_ff;

endmodule

FILE: hw/rtl/ray_box_intersect_3d_unit.sv
// ----------------------------------------------------------------------------
// Ray/box intersect unit
// Slab-method ray versus axis-aligned box test with entry distance, impact
// point and face normal.
// ----------------------------------------------------------------------------
// Takes one ray/box beat per cycle while not stalled and returns one result
// beat per input beat, in order. Most of the depth is in the six slab dividers,
// which resolve one quotient bit per stage. When the result beat is not taken
// the whole pipeline holds. The user must write the length limit register
// through the csr port only while the unit is idle; no logic enforces it.
module ray_box_intersect_3d_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [COORD_WIDTH-2:0]        csr_max_ray_length,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_z,
   input  logic signed [FRAC_BITS+1:0]   req_dir_x,
   input  logic signed [FRAC_BITS+1:0]   req_dir_y,
   input  logic signed [FRAC_BITS+1:0]   req_dir_z,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_min_z,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_max_z,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [COORD_WIDTH-2:0]        rsp_hit_distance,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_x,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_y,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_z,
   output logic signed [FRAC_BITS+1:0]   rsp_normal_x,
   output logic signed [FRAC_BITS+1:0]   rsp_normal_y,
   output logic signed [FRAC_BITS+1:0]   rsp_normal_z
);

`include "ray_box_intersect_3d_unit_macros.svh"

   localparam int CW    = COORD_WIDTH;
   localparam int FB    = FRAC_BITS;
   localparam int DW    = FB + 2;
   localparam int DLY   = CW + 2;
   localparam int TOTAL = CW + 7;

   logic              adv;
   logic [TOTAL-1:0]  valid_ff;
   logic [CW-2:0]     max_len_ff;

   logic signed [CW-1:0] in_s  [3];
   logic signed [DW-1:0] in_d  [3];
   logic signed [CW-1:0] in_lo [3];
   logic signed [CW-1:0] in_hi [3];

   assign in_s  = '{req_start_x, req_start_y, req_start_z};
   assign in_d  = '{req_dir_x, req_dir_y, req_dir_z};
   assign in_lo = '{req_box_min_x, req_box_min_y, req_box_min_z};
   assign in_hi = '{req_box_max_x, req_box_max_y, req_box_max_z};

   assign adv       = !valid_ff[TOTAL-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = valid_ff[TOTAL-1];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         max_len_ff <= '1;
      end else begin
         if (adv) begin
            valid_ff <= {valid_ff[TOTAL-2:0], req_valid};
         end
         if (csr_valid) begin
            max_len_ff <= csr_max_ray_length;
         end
      end
   end

   // front stage: slab offsets and position flags
   rbi_pkg::rbi_flags_type flags_c;
   logic signed [CW:0]   dlo_ff [3];
   logic signed [CW:0]   dhi_ff [3];
   logic signed [CW-1:0] s_ff   [DLY+1][3];
   logic signed [DW-1:0] d_ff   [DLY+1][3];
   rbi_pkg::rbi_flags_type fl_ff [DLY+1];

   always_comb begin
      flags_c.in_box = 1'b1;
      flags_c.zmiss  = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (!((in_s[a] > in_lo[a]) && (in_s[a] < in_hi[a]))) begin
            flags_c.in_box = 1'b0;
         end
         if ((in_d[a] == '0) && ((in_s[a] < in_lo[a]) || (in_s[a] > in_hi[a]))) begin
            flags_c.zmiss = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            dlo_ff[a] <= {in_lo[a][CW-1], in_lo[a]} - {in_s[a][CW-1], in_s[a]};
            dhi_ff[a] <= {in_hi[a][CW-1], in_hi[a]} - {in_s[a][CW-1], in_s[a]};
         end
         s_ff[0]  <= in_s;
         d_ff[0]  <= in_d;
         fl_ff[0] <= flags_c;
         for (int k = 1; k <= DLY; k++) begin
            s_ff[k]  <= s_ff[k-1];
            d_ff[k]  <= d_ff[k-1];
            fl_ff[k] <= fl_ff[k-1];
         end
      end
   end

   logic signed [CW-1:0] t_lo [3];
   logic signed [CW-1:0] t_hi [3];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbi_slab_div #(.CW(CW), .FB(FB)) u_div_lo (
         .clock (clock),
         .en    (adv),
         .num   (dlo_ff[a]),
         .den   (d_ff[0][a]),
         .quo   (t_lo[a])
      );
      rbi_slab_div #(.CW(CW), .FB(FB)) u_div_hi (
         .clock (clock),
         .en    (adv),
         .num   (dhi_ff[a]),
         .den   (d_ff[0][a]),
         .quo   (t_hi[a])
      );
   end

   logic signed [CW-1:0] pos [3];
   logic signed [DW-1:0] nrm [3];

   rbi_resolve #(.CW(CW), .FB(FB)) u_resolve (
      .clock    (clock),
      .en       (adv),
      .max_len  (max_len_ff),
      .flags    (fl_ff[DLY]),
      .t_lo     (t_lo),
      .t_hi     (t_hi),
      .s        (s_ff[DLY]),
      .d        (d_ff[DLY]),
      .hit      (rsp_hit),
      .hit_dist (rsp_hit_distance),
      .pos      (pos),
      .nrm      (nrm)
   );

   assign rsp_hit_x    = pos[0];
   assign rsp_hit_y    = pos[1];
   assign rsp_hit_z    = pos[2];
   assign rsp_normal_x = nrm[0];
   assign rsp_normal_y = nrm[1];
   assign rsp_normal_z = nrm[2];

   `RBI_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, (rsp_hit_distance == '0) && (rsp_hit_x == '0) && (rsp_hit_y == '0) && (rsp_hit_z == '0) && (rsp_normal_x == '0) && (rsp_normal_y == '0) && (rsp_normal_z == '0))
   `RBI_ASSERT_NOW(a_dist_limit, clock, reset, rsp_valid && rsp_hit, rsp_hit_distance <= max_len_ff)
   `RBI_ASSERT_NEXT(a_stall_hold, clock, reset, !adv, valid_ff == $past(valid_ff))

endmodule
